/* sv/hsf8_pkg.sv */
// Shared types, widths and constants for the horizontal 8-tap sub-pixel filter.
// No dependencies; every other file of the block imports this package.
package hsf8_pkg;

    // Fixed field widths
    localparam int PIXEL_W    = 12;
    localparam int TAP_W      = 16;
    localparam int TAP_COUNT  = 8;
    localparam int HELD_COUNT = TAP_COUNT - 1;
    localparam int FILL_W     = 3;
    localparam int BD_W       = 4;
    localparam int SAT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Unsigned pixel times signed tap, and the sum of eight plus rounding
    localparam int PROD_W = PIXEL_W + 1 + TAP_W;
    localparam int ACC_W  = PROD_W + 4;

    // Default values of the top-level parameters
    localparam int ROUND_SHIFT_DEF     = 7;
    localparam int MAX_SAMPLE_BITS_DEF = 12;
    localparam int QUEUE_DEPTH_DEF     = 4;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] TAPS_LO_RST = 64'h0080_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] TAPS_HI_RST = 64'h0;
    localparam logic [BD_W-1:0]       BD_RST      = 4'd8;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAPS_LO   = 2'd0,
        CFG_TAPS_HI   = 2'd1,
        CFG_BIT_DEPTH = 2'd2,
        CFG_AVG_EN    = 2'd3
    } t_cfg_idx;

    // Configuration seen by the filter datapath
    typedef struct packed {
        logic [CFG_DATA_W-1:0] taps_lo;
        logic [CFG_DATA_W-1:0] taps_hi;
        logic [BD_W-1:0]       bit_depth;
        logic                  avg_en;
    } t_cfg;

    // One full window plus the destination pixel, oldest sample at index 0
    typedef struct packed {
        logic [TAP_COUNT-1:0][PIXEL_W-1:0] samples;
        logic [PIXEL_W-1:0]                prior;
    } t_win_item;

endpackage

/* sv/hsf8_front.sv */
// Front end: takes input items, runs the seven-sample delay line and fill count,
// and forwards complete windows. Depends on hsf8_pkg.
module hsf8_front
    import hsf8_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [PIXEL_W-1:0] i_sample_in,
    input  logic [PIXEL_W-1:0] i_prior_pixel,
    input  logic               i_row_start,
    output logic               o_push,
    output t_win_item          o_item
);

    logic [HELD_COUNT-1:0][PIXEL_W-1:0] r_win;
    logic [FILL_W-1:0]                  r_fill;
    logic [FILL_W-1:0]                  fill_eff;
    logic                               full_win;

    // A row start restarts the fill before the sample is counted
    assign fill_eff = i_row_start ? '0 : r_fill;
    assign full_win = (fill_eff == FILL_W'(HELD_COUNT));
    assign o_push   = i_accept && full_win;

    // Window: held samples oldest first, newest from the port
    always_comb begin
        for (int k = 0; k < HELD_COUNT; k++) begin
            o_item.samples[k] = r_win[k];
        end
        o_item.samples[TAP_COUNT-1] = i_sample_in;
        o_item.prior                = i_prior_pixel;
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_accept) begin
            r_fill <= full_win ? fill_eff : fill_eff + FILL_W'(1);
        end
    end

    // Delay line, shifts on every accepted item
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int k = 0; k < HELD_COUNT - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[HELD_COUNT-1] <= i_sample_in;
        end
    end

endmodule

/* sv/hsf8_queue.sv */
// Short FIFO of complete windows between front end and filter datapath.
// Depends on hsf8_pkg for the item type.
module hsf8_queue
    import hsf8_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_win_item i_item,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_win_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_win_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* sv/hsf8_back.sv */
// Filter datapath: products, sum with rounding, clamp and average, output register.
// The whole pipe advances together when the output is free. Depends on hsf8_pkg.
module hsf8_back
    import hsf8_pkg::*;
#(
    parameter int ROUND_SHIFT     = ROUND_SHIFT_DEF,
    parameter int MAX_SAMPLE_BITS = MAX_SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_win_item          i_q_item,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [PIXEL_W-1:0] o_pixel_out
);

    localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1) <<< (ROUND_SHIFT - 1);
    localparam logic [BD_W-1:0]         BD_MAX    = BD_W'(MAX_SAMPLE_BITS);

    logic signed [TAP_W-1:0]  tap    [TAP_COUNT];
    logic signed [PROD_W-1:0] n_prod [TAP_COUNT];
    logic signed [PROD_W-1:0] r_prod [TAP_COUNT];
    logic [PIXEL_W-1:0]       r_s1_prior;
    logic                     r_s1_vld;

    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  r_acc;
    logic [PIXEL_W-1:0]       r_s2_prior;
    logic                     r_s2_vld;

    logic [ACC_W-1:0]         quot;
    logic [SAT_W-1:0]         sat;
    logic [BD_W-1:0]          bd;
    logic [SAT_W-1:0]         limit;
    logic [SAT_W-1:0]         lim_pix;
    logic [SAT_W:0]           avg_sum;
    logic [PIXEL_W-1:0]       n_pixel;
    logic [PIXEL_W-1:0]       r_pixel;
    logic                     r_out_vld;

    logic                     advance;

    assign advance     = !r_out_vld || !i_out_stall;
    assign o_q_pop     = advance && i_q_valid;
    assign o_out_valid = r_out_vld;
    assign o_pixel_out = r_pixel;

    // Tap fields and products
    always_comb begin
        for (int k = 0; k < TAP_COUNT; k++) begin
            if (k < 4) begin
                tap[k] = i_cfg.taps_lo[16*k +: TAP_W];
            end else begin
                tap[k] = i_cfg.taps_hi[16*(k-4) +: TAP_W];
            end
            n_prod[k] = $signed({1'b0, i_q_item.samples[k]}) * tap[k];
        end
    end

    // Sum of products plus rounding constant
    always_comb begin
        n_acc = ROUND_ADD;
        for (int k = 0; k < TAP_COUNT; k++) begin
            n_acc = n_acc + ACC_W'(r_prod[k]);
        end
    end

    // Shift, saturate, bit-depth limit, optional average
    always_comb begin
        quot    = ACC_W'(r_acc >>> ROUND_SHIFT);
        if (r_acc < 0) begin
            sat = '0;
        end else if (quot > ACC_W'({SAT_W{1'b1}})) begin
            sat = '1;
        end else begin
            sat = quot[SAT_W-1:0];
        end
        bd      = (i_cfg.bit_depth > BD_MAX) ? BD_MAX : i_cfg.bit_depth;
        limit   = SAT_W'(((SAT_W+1)'(1) << bd) - (SAT_W+1)'(1));
        lim_pix = (sat > limit) ? limit : sat;
        avg_sum = (SAT_W+1)'(lim_pix) + (SAT_W+1)'(r_s2_prior) + (SAT_W+1)'(1);
        n_pixel = i_cfg.avg_en ? avg_sum[PIXEL_W:1] : lim_pix[PIXEL_W-1:0];
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_s1_vld  <= i_q_valid;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld;
        end
    end

    // Stage data
    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int k = 0; k < TAP_COUNT; k++) begin
                r_prod[k] <= n_prod[k];
            end
            r_s1_prior <= i_q_item.prior;
            r_acc      <= n_acc;
            r_s2_prior <= r_s1_prior;
            r_pixel    <= n_pixel;
        end
    end

endmodule

/* sv/highbd_subpel_horiz_fir8.sv */
// Horizontal 8-tap sub-pixel filter, high bit depth, one sample accepted per cycle while
// o_in_stall is low. A window's last sample reaches the output via the queue write,
// product, sum and clamp/average stage registers. Throughput: 1 item/cycle, set by the
// fully pipelined multiply/sum datapath; the window queue absorbs output stalls until full.
// Synchronous active-low reset clears fill count, queue and stage valids and sets config
// to pass-through taps, bit depth 8, averaging off. Depends on hsf8_pkg and submodules.
module highbd_subpel_horiz_fir8
    import hsf8_pkg::*;
#(
    parameter int ROUND_SHIFT     = ROUND_SHIFT_DEF,
    parameter int MAX_SAMPLE_BITS = MAX_SAMPLE_BITS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIXEL_W-1:0]    i_sample_in,
    input  logic [PIXEL_W-1:0]    i_prior_pixel,
    input  logic                  i_row_start,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIXEL_W-1:0]    o_pixel_out
);

    t_cfg      r_cfg;
    logic      in_accept;
    logic      push;
    t_win_item front_item;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    t_win_item q_item;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.taps_lo   <= TAPS_LO_RST;
            r_cfg.taps_hi   <= TAPS_HI_RST;
            r_cfg.bit_depth <= BD_RST;
            r_cfg.avg_en    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TAPS_LO:   r_cfg.taps_lo   <= i_cfg_data;
                CFG_TAPS_HI:   r_cfg.taps_hi   <= i_cfg_data;
                CFG_BIT_DEPTH: r_cfg.bit_depth <= i_cfg_data[BD_W-1:0];
                CFG_AVG_EN:    r_cfg.avg_en    <= i_cfg_data[0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // Delay line and window classification
    hsf8_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_sample_in   (i_sample_in),
        .i_prior_pixel (i_prior_pixel),
        .i_row_start   (i_row_start),
        .o_push        (push),
        .o_item        (front_item)
    );

    // Window queue
    hsf8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Filter datapath
    hsf8_back #(
        .ROUND_SHIFT     (ROUND_SHIFT),
        .MAX_SAMPLE_BITS (MAX_SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel_out (o_pixel_out)
    );

endmodule
